### hdl/dasd_pkg.sv
// dasd_pkg: shared types, constants and the month length table for the
// date adder. Used by dasd_ctrl, dasd_dp and date_add_signed_days.
package dasd_pkg;

    // fixed calendar constants
    localparam int MONTHS    = 12;
    localparam int YEAR_DAYS = 365;
    // narrow day register used by the month walk, holds -364..365
    localparam int WLK_W     = 10;
    // remainder width of the divide-by-365 unit
    localparam int REM_W     = 9;

    // floor of 2**32 / 365; for dividends below 2**32 the product estimate
    // is the quotient or one below it
    localparam int                 RECIP_SH  = 32;
    localparam int                 RECIP_W   = 24;
    localparam logic [RECIP_W-1:0] RECIP_365 = 24'd11767033;
    localparam int                 PROD_W    = RECIP_SH + RECIP_W;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    // controller to datapath commands
    typedef struct packed {
        logic load;       // capture an input item
        logic div_step;   // quotient estimate by reciprocal multiply
        logic div_fix;    // remainder and one-step quotient correction
        logic apply;      // fold quotient and remainder into year and day
        logic walk_step;  // move one month forward or back
        logic emit;       // load the output register
    } dasd_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic need_div;   // day sum spans a whole year or more
        logic walk_done;  // day lies inside the current month
    } dasd_sts_t;

    // days in a month, february fixed at 28
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd2:    len = 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

### hdl/dasd_ctrl.sv
// dasd_ctrl: sequencing state machine of the date adder.
// Depends on dasd_pkg for the command and status structs.
module dasd_ctrl import dasd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  dasd_sts_t sts,
    output dasd_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_FIX,
        ST_APPLY,
        ST_WALK
    } state_t;

    state_t        state_reg, state_next;
    logic          m_valid_reg, m_valid_next;
    logic          out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (sts.need_div) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_WALK;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                state_next   = ST_FIX;
            end
            ST_FIX: begin
                cmd.div_fix = 1'b1;
                state_next  = ST_APPLY;
            end
            ST_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (!sts.walk_done) begin
                    cmd.walk_step = 1'b1;
                end else if (out_free) begin
                    cmd.emit     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTHESIS
    // a result never overwrites one that is still waiting
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_tready))
        else $error("dasd_ctrl: output overwritten");

    // a result is only produced once the day is inside its month
    a_emit_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.walk_done)
        else $error("dasd_ctrl: emit before walk finished");

    // the quotient estimate is always followed by its correction
    a_div_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |=> (state_reg == ST_FIX))
        else $error("dasd_ctrl: divider did not finish");

    // no new item while one is in progress
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("dasd_ctrl: item accepted during work");
`endif

endmodule

### hdl/dasd_dp.sv
// dasd_dp: datapath of the date adder: input capture, reciprocal divide by
// 365 for whole years, month walk and output register. Depends on dasd_pkg.
module dasd_dp import dasd_pkg::*; #(
    parameter int OFFSET_BITS = 17,
    parameter int YEAR_BITS   = 16
) (
    input  logic                   aclk,
    input  dasd_cmd_t              cmd,
    output dasd_sts_t              sts,
    input  logic [3:0]             in_month,
    input  logic [4:0]             in_day,
    input  logic [YEAR_BITS-1:0]   in_year,
    input  logic [OFFSET_BITS-1:0] day_offset,
    output logic [3:0]             out_month,
    output logic [4:0]             out_day,
    output logic [YEAR_BITS-1:0]   out_year,
    output logic                   out_of_range
);

    localparam int MW = OFFSET_BITS;
    localparam int DW = OFFSET_BITS + 2;
    localparam int RW = OFFSET_BITS + 2;
    localparam int YX = ((YEAR_BITS > OFFSET_BITS) ? YEAR_BITS : OFFSET_BITS) + 2;

    logic [3:0]       month_reg, month_next;
    logic [YX-1:0]    year_reg, year_next;
    logic [WLK_W-1:0] wlk_reg, wlk_next;
    logic [MW-1:0]    mag_reg, mag_next;
    logic [MW-1:0]    quo_reg, quo_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic             neg_reg, neg_next;
    logic             div_reg, div_next;
    logic [3:0]       out_month_reg;
    logic [4:0]       out_day_reg;
    logic [YEAR_BITS-1:0] out_year_reg;
    logic             out_oor_reg;

    logic [DW-1:0]    sum_w;
    logic             pos_big, neg_big;
    logic [DW-1:0]    mag_w;
    logic [3:0]       ld_month;
    logic [YX-1:0]    ld_year;
    logic [PROD_W-1:0] prod_w;
    logic [RW-1:0]    q365_w;
    logic [RW-1:0]    rem_full;
    logic             fix;
    logic [4:0]       len_cur, len_prev;
    logic [3:0]       prev_month, nxt_month;
    logic             d_le0, d_gt;
    logic [YX-YEAR_BITS:0] year_hi;

    // starting day plus offset, and whether whole years must be stripped
    assign sum_w   = {{(DW-5){1'b0}}, in_day}
                   + {{(DW-OFFSET_BITS){day_offset[OFFSET_BITS-1]}}, day_offset};
    assign pos_big = !sum_w[DW-1] && (sum_w > DW'(YEAR_DAYS));
    assign neg_big = sum_w[DW-1] && (sum_w <= DW'(-YEAR_DAYS));
    assign mag_w   = pos_big ? (sum_w - DW'(1)) : (DW'(0) - sum_w);

    // month zero and months past december fold into the year
    always_comb begin
        ld_year  = {{(YX-YEAR_BITS){in_year[YEAR_BITS-1]}}, in_year};
        ld_month = in_month;
        if (in_month == 4'd0) begin
            ld_month = MONTH_DEC;
            ld_year  = ld_year - YX'(1);
        end else if (in_month > MONTH_DEC) begin
            ld_month = in_month - MONTH_DEC;
            ld_year  = ld_year + YX'(1);
        end
    end

    // divide by 365: reciprocal estimate, then remainder and one correction
    assign prod_w   = {{(PROD_W-MW){1'b0}}, mag_reg}
                    * {{(PROD_W-RECIP_W){1'b0}}, RECIP_365};
    assign q365_w   = {2'b00, quo_reg} * RW'(YEAR_DAYS);
    assign rem_full = {2'b00, mag_reg} - q365_w;
    assign fix      = (rem_full >= RW'(YEAR_DAYS));

    // month walk terms
    assign len_cur    = month_len(month_reg);
    assign prev_month = (month_reg == MONTH_JAN) ? MONTH_DEC : (month_reg - 4'd1);
    assign nxt_month  = (month_reg == MONTH_DEC) ? MONTH_JAN : (month_reg + 4'd1);
    assign len_prev   = month_len(prev_month);
    assign d_le0      = wlk_reg[WLK_W-1] || (wlk_reg == '0);
    assign d_gt       = !wlk_reg[WLK_W-1] && (wlk_reg > {{(WLK_W-5){1'b0}}, len_cur});

    assign sts.need_div  = div_reg;
    assign sts.walk_done = !d_le0 && !d_gt;

    // next values of the working registers
    always_comb begin
        month_next = month_reg;
        year_next  = year_reg;
        wlk_next   = wlk_reg;
        mag_next   = mag_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        div_next   = div_reg;
        if (cmd.load) begin
            month_next = ld_month;
            year_next  = ld_year;
            wlk_next   = sum_w[WLK_W-1:0];
            mag_next   = mag_w[MW-1:0];
            quo_next   = '0;
            rem_next   = '0;
            neg_next   = neg_big;
            div_next   = pos_big || neg_big;
        end else if (cmd.div_step) begin
            quo_next = MW'(prod_w[PROD_W-1:RECIP_SH]);
        end else if (cmd.div_fix) begin
            rem_next = fix ? REM_W'(rem_full - RW'(YEAR_DAYS)) : REM_W'(rem_full);
            quo_next = quo_reg + {{(MW-1){1'b0}}, fix};
        end else if (cmd.apply) begin
            if (neg_reg) begin
                year_next = year_reg - {{(YX-MW){1'b0}}, quo_reg};
                wlk_next  = WLK_W'(0) - {1'b0, rem_reg};
            end else begin
                year_next = year_reg + {{(YX-MW){1'b0}}, quo_reg};
                wlk_next  = {1'b0, rem_reg} + WLK_W'(1);
            end
        end else if (cmd.walk_step) begin
            if (d_le0) begin
                month_next = prev_month;
                wlk_next   = wlk_reg + {{(WLK_W-5){1'b0}}, len_prev};
                if (month_reg == MONTH_JAN) begin
                    year_next = year_reg - YX'(1);
                end
            end else if (d_gt) begin
                month_next = nxt_month;
                wlk_next   = wlk_reg - {{(WLK_W-5){1'b0}}, len_cur};
                if (month_reg == MONTH_DEC) begin
                    year_next = year_reg + YX'(1);
                end
            end
        end
    end

    // exact year fits when all bits above the sign agree
    assign year_hi = year_reg[YX-1:YEAR_BITS-1];

    // working and output registers
    always_ff @(posedge aclk) begin
        month_reg <= month_next;
        year_reg  <= year_next;
        wlk_reg   <= wlk_next;
        mag_reg   <= mag_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        neg_reg   <= neg_next;
        div_reg   <= div_next;
        if (cmd.emit) begin
            out_month_reg <= month_reg;
            out_day_reg   <= wlk_reg[4:0];
            out_year_reg  <= year_reg[YEAR_BITS-1:0];
            out_oor_reg   <= !((&year_hi) || !(|year_hi));
        end
    end

    assign out_month    = out_month_reg;
    assign out_day      = out_day_reg;
    assign out_year     = out_year_reg;
    assign out_of_range = out_oor_reg;

endmodule

### hdl/date_add_signed_days.sv
// date_add_signed_days: top level of the signed day adder for a fixed
// 365-day calendar. Instantiates dasd_ctrl and dasd_dp; uses dasd_pkg.
//
//   channel | direction | tdata (low bit first)                        | tuser
//   s_      | in        | in_month, in_day, in_year, day_offset        | -
//   m_      | out       | out_month, out_day, out_year                 | out_of_range
//
// One item at a time: after the accept and a setup state, whole years are
// stripped in three steps (reciprocal multiply, remainder with correction,
// apply) when the day sum spans a year or more; then the month walk moves
// one month per cycle until the day lies inside its month, and the result
// is loaded into the output register, which raises m_tvalid.
// Reset is synchronous and active low; it clears the controller only.
// s_tready is high while idle; a finished result waits in the output
// register and the next item is taken while it waits; if it still waits
// when the next walk ends, the controller holds and s_tready stays low.
module date_add_signed_days import dasd_pkg::*; #(
    parameter int OFFSET_BITS = 17,
    parameter int YEAR_BITS   = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // in_month[3:0], in_day[4:0], in_year, day_offset, zero pad
    input  logic [((9 + YEAR_BITS + OFFSET_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // out_month[3:0], out_day[4:0], out_year, zero pad
    output logic [((9 + YEAR_BITS + 7) / 8) * 8 - 1:0]               m_tdata,
    // out_of_range
    output logic                m_tuser
);

    localparam int M_BITS = 9 + YEAR_BITS;
    localparam int M_W    = ((M_BITS + 7) / 8) * 8;

    dasd_cmd_t            cmd;
    dasd_sts_t            sts;
    logic [3:0]           out_month;
    logic [4:0]           out_day;
    logic [YEAR_BITS-1:0] out_year;

    dasd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dasd_dp #(
        .OFFSET_BITS (OFFSET_BITS),
        .YEAR_BITS   (YEAR_BITS)
    ) u_dp (
        .aclk         (aclk),
        .cmd          (cmd),
        .sts          (sts),
        .in_month     (s_tdata[3:0]),
        .in_day       (s_tdata[8:4]),
        .in_year      (s_tdata[9 +: YEAR_BITS]),
        .day_offset   (s_tdata[9 + YEAR_BITS +: OFFSET_BITS]),
        .out_month    (out_month),
        .out_day      (out_day),
        .out_year     (out_year),
        .out_of_range (m_tuser)
    );

    // pack result item
    assign m_tdata = M_W'({out_year, out_day, out_month});

endmodule
